[src/psi6_order_parameter_top_macros.svh]
// Assertion macros used by the psi6 back end of the order parameter RTL
`ifndef PSI6_ORDER_PARAMETER_TOP_MACROS_SVH
`define PSI6_ORDER_PARAMETER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define PSI6_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PSI6_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/psi6_pkg.sv]
// Types, constants and tables for the psi6 order parameter block
package psi6_pkg;

  localparam int MAX_BONDS   = 64;
  localparam int MAX_POINTS  = 1048576;
  localparam int FRAC_BITS   = 16;
  localparam int CORDIC_STEPS = 30;

  localparam int BOND_CNT_W  = 7;
  localparam int POINT_CNT_W = 21;
  localparam int UNIT_W      = FRAC_BITS + 2;
  localparam int PSUM_W      = 24;
  localparam int TSUM_W      = 40;
  localparam int DIV_NUM_W   = 41;
  localparam int DIV_DEN_W   = 21;
  localparam int MAG_W       = FRAC_BITS + 1;
  localparam int SQ_W        = 2 * MAG_W + 1;
  localparam int CORDIC_W    = 34;

  // 6 * 2^33 / (2*pi), phase in units of 2^-32 turn
  localparam logic signed [35:0] PHASE_MULT = 36'sd8202783306;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [19:0] bond_angle;
    logic               end_of_point;
    logic               end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [16:0] order_magnitude;
    logic [20:0] points_seen;
    logic        count_overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] phase;
    logic        eop;
    logic        eos;
  } q_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] phase;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [UNIT_W-1:0] re;
    logic signed [UNIT_W-1:0] im;
  } cordic_rsp_t;

  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41721;
      5'd15: v = 30'd20860;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2607;
      5'd19: v = 30'd1303;
      5'd20: v = 30'd651;
      5'd21: v = 30'd325;
      5'd22: v = 30'd162;
      5'd23: v = 30'd81;
      5'd24: v = 30'd40;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd2;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[src/psi6_stream_if.sv]
// Valid/ready stream interface carrying one payload item
interface psi6_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/psi6_front.sv]
// Front end: accepts angles, forms the 6*theta phase, queues items
module psi6_front
  import psi6_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  psi6_stream_if.sink     items,
  output logic            q_valid,
  output q_item_t         q_data,
  input  logic            q_pop
);

  q_item_t            entry [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic signed [55:0] prod;
  logic [55:0]        prod_rnd;
  logic               push;
  logic               pop;

  assign prod     = 56'(items.data.bond_angle) * 56'(PHASE_MULT);
  assign prod_rnd = prod + 56'd32768;

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign pop         = q_pop && q_valid;
  assign q_valid     = (count != 2'd0);
  assign q_data      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr].phase <= prod_rnd[47:16];
      entry[wr_ptr].eop   <= items.data.end_of_point;
      entry[wr_ptr].eos   <= items.data.end_of_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[src/psi6_cordic.sv]
// Iterative CORDIC: one rotation step per cycle, gives cos and sin of a phase
module psi6_cordic
  import psi6_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic signed [CORDIC_W-1:0] x, y, z;
  logic [4:0]                 step;
  logic                       busy;
  logic [1:0]                 quad;
  logic [31:0]                q_sum;
  logic [31:0]                z_init;
  logic signed [CORDIC_W-1:0] xs, ys;
  logic signed [CORDIC_W-1:0] at;
  logic signed [CORDIC_W-1:0] c_rnd, s_rnd;
  logic signed [UNIT_W-1:0]   c, s;
  logic                       done;
  logic signed [UNIT_W-1:0]   turn_re, turn_im;

  assign q_sum  = req.phase + 32'h2000_0000;
  assign z_init = req.phase - {q_sum[31:30], 30'd0};
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign at     = CORDIC_W'(atan_turns(step));
  assign c_rnd  = (x + CORDIC_W'(1 << 13)) >>> 14;
  assign s_rnd  = (y + CORDIC_W'(1 << 13)) >>> 14;

  function automatic logic signed [UNIT_W-1:0] clamp(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] lim;
    lim = CORDIC_W'(1 << FRAC_BITS);
    if (v > lim)       return UNIT_W'(lim);
    else if (v < -lim) return UNIT_W'(-lim);
    else               return UNIT_W'(v);
  endfunction

  assign c = clamp(c_rnd);
  assign s = clamp(s_rnd);

  assign rsp = {done, turn_re, turn_im};

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= CORDIC_W'(signed'(z_init));
      quad <= q_sum[31:30];
    end else if (busy) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= !busy && (step == 5'(CORDIC_STEPS));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end
        step <= step + 5'd1;
      end else if (step == 5'(CORDIC_STEPS)) begin
        step <= '0;
      end
    end
  end

  // turn the result by the split-off quarter turns
  always_ff @(posedge clk) begin
    if (!busy && step == 5'(CORDIC_STEPS)) begin
      unique case (quad)
        2'd0: begin turn_re <= c;  turn_im <= s;  end
        2'd1: begin turn_re <= -s; turn_im <= c;  end
        2'd2: begin turn_re <= -c; turn_im <= -s; end
        2'd3: begin turn_re <= s;  turn_im <= -c; end
        default: begin turn_re <= c; turn_im <= s; end
      endcase
    end
  end

endmodule

[src/psi6_divider.sv]
// Restoring divider, one quotient bit per cycle
module psi6_divider
  import psi6_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [5:0]           cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign rem_sh  = {rem, quo[DIV_NUM_W-1]};
  assign diff    = rem_sh - {1'b0, den};
  assign fits    = (rem_sh >= {1'b0, den});
  assign rsp     = {done, quo};

  always_ff @(posedge clk) begin
    if (req.start) begin
      den <= req.den;
      rem <= '0;
      quo <= req.num;
    end else if (busy) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == 6'(DIV_NUM_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[src/psi6_back.sv]
// Back end: accumulates unit vectors, averages per point and per set, forms magnitude
module psi6_back
  import psi6_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  q_item_t      q_data,
  output logic         q_pop,
  psi6_stream_if.source results
);

  `include "psi6_order_parameter_top_macros.svh"

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CORD   = 12'b000000000010,
    S_PCLOSE = 12'b000000000100,
    S_PDIVR  = 12'b000000001000,
    S_PDIVI  = 12'b000000010000,
    S_SCLOSE = 12'b000000100000,
    S_SDIVR  = 12'b000001000000,
    S_SDIVI  = 12'b000010000000,
    S_SQ1    = 12'b000100000000,
    S_SQ2    = 12'b001000000000,
    S_SQRT   = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t state;

  logic [BOND_CNT_W-1:0]    bond_count;
  logic [POINT_CNT_W-1:0]   points_done;
  logic signed [PSUM_W-1:0] point_sum_real, point_sum_imag;
  logic signed [TSUM_W-1:0] total_sum_real, total_sum_imag;
  logic                     overflow_seen;
  logic                     eop, eos;
  logic [MAG_W-1:0]         avg_re, avg_im;
  logic [SQ_W-1:0]          sq;
  logic [SQ_W:0]            root;
  logic [SQ_W-1:0]          bitv;
  logic [4:0]               sq_cnt;
  logic                     out_free;
  logic                     cor_start;
  logic                     div_start;

  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic signed [PSUM_W-1:0] pdiv_src;
  logic [PSUM_W-1:0]        pdiv_mag;
  logic signed [TSUM_W-1:0] sdiv_src;
  logic [TSUM_W-1:0]        sdiv_mag;
  logic signed [TSUM_W-1:0] pquo_signed;
  logic                     pquo_neg;
  logic [SQ_W:0]            trial;
  logic [2*MAG_W-1:0]       sq_term;
  logic [MAG_W-1:0]         sq_op;
  logic [SQ_W:0]            root_rnd;

  psi6_cordic u_cordic (.clk, .rst, .req(cor_req), .rsp(cor_rsp));
  psi6_divider u_divider (.clk, .rst, .req(div_req), .rsp(div_rsp));

  assign out_free = !results.valid || results.ready;
  assign q_pop    = (state == S_IDLE) && q_valid;

  assign cor_start = (state == S_IDLE) && q_valid &&
                     (bond_count < BOND_CNT_W'(MAX_BONDS));
  assign div_start = ((state == S_PCLOSE) && (eop || eos) &&
                      (points_done < POINT_CNT_W'(MAX_POINTS))) ||
                     (((state == S_PDIVR) || (state == S_SDIVR)) && div_rsp.done) ||
                     (state == S_SCLOSE);

  assign pdiv_src = (state == S_PCLOSE) ? point_sum_real : point_sum_imag;
  assign pdiv_mag = pdiv_src[PSUM_W-1] ? PSUM_W'(-pdiv_src) : PSUM_W'(pdiv_src);
  assign sdiv_src = (state == S_SCLOSE) ? total_sum_real : total_sum_imag;
  assign sdiv_mag = sdiv_src[TSUM_W-1] ? TSUM_W'(-sdiv_src) : TSUM_W'(sdiv_src);

  assign pquo_neg    = (state == S_PDIVR) ? point_sum_real[PSUM_W-1]
                                          : point_sum_imag[PSUM_W-1];
  assign pquo_signed = pquo_neg ? -TSUM_W'(div_rsp.quo) : TSUM_W'(div_rsp.quo);

  assign sq_op   = (state == S_SQ1) ? avg_re : avg_im;
  assign sq_term = sq_op * sq_op;
  assign trial   = root + {1'b0, bitv};
  assign root_rnd = ({1'b0, sq} > root) ? root + 1'b1 : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bond_count     <= '0;
      points_done    <= '0;
      point_sum_real <= '0;
      point_sum_imag <= '0;
      total_sum_real <= '0;
      total_sum_imag <= '0;
      overflow_seen  <= 1'b0;
      cor_req.start  <= 1'b0;
      div_req.start  <= 1'b0;
      results.valid  <= 1'b0;
    end else begin
      cor_req.start <= cor_start;
      div_req.start <= div_start;
      if (results.valid && results.ready && state != S_EMIT) results.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            eop <= q_data.eop;
            eos <= q_data.eos;
            if (bond_count >= BOND_CNT_W'(MAX_BONDS)) begin
              // drop the bond, its end flags still act
              overflow_seen <= 1'b1;
              state         <= S_PCLOSE;
            end else begin
              cor_req.phase <= q_data.phase;
              state         <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (cor_rsp.done) begin
            point_sum_real <= point_sum_real + PSUM_W'(cor_rsp.re);
            point_sum_imag <= point_sum_imag + PSUM_W'(cor_rsp.im);
            bond_count     <= bond_count + 1'b1;
            state          <= S_PCLOSE;
          end
        end
        S_PCLOSE: begin
          if (!(eop || eos)) begin
            state <= S_IDLE;
          end else if (points_done >= POINT_CNT_W'(MAX_POINTS)) begin
            overflow_seen  <= 1'b1;
            bond_count     <= '0;
            point_sum_real <= '0;
            point_sum_imag <= '0;
            state          <= eos ? S_SCLOSE : S_IDLE;
          end else begin
            div_req.num   <= DIV_NUM_W'(pdiv_mag) + DIV_NUM_W'(bond_count >> 1);
            div_req.den   <= DIV_DEN_W'(bond_count);
            state         <= S_PDIVR;
          end
        end
        S_PDIVR: begin
          if (div_rsp.done) begin
            total_sum_real <= total_sum_real + pquo_signed;
            div_req.num    <= DIV_NUM_W'(pdiv_mag) + DIV_NUM_W'(bond_count >> 1);
            state          <= S_PDIVI;
          end
        end
        S_PDIVI: begin
          if (div_rsp.done) begin
            total_sum_imag <= total_sum_imag + pquo_signed;
            points_done    <= points_done + 1'b1;
            bond_count     <= '0;
            point_sum_real <= '0;
            point_sum_imag <= '0;
            state          <= eos ? S_SCLOSE : S_IDLE;
          end
        end
        S_SCLOSE: begin
          div_req.num   <= DIV_NUM_W'(sdiv_mag) + DIV_NUM_W'(points_done >> 1);
          div_req.den   <= points_done;
          state         <= S_SDIVR;
        end
        S_SDIVR: begin
          if (div_rsp.done) begin
            avg_re        <= (points_done == '0) ? '0 : div_rsp.quo[MAG_W-1:0];
            div_req.num   <= DIV_NUM_W'(sdiv_mag) + DIV_NUM_W'(points_done >> 1);
            state         <= S_SDIVI;
          end
        end
        S_SDIVI: begin
          if (div_rsp.done) begin
            avg_im <= (points_done == '0) ? '0 : div_rsp.quo[MAG_W-1:0];
            state  <= S_SQ1;
          end
        end
        S_SQ1: begin
          sq    <= SQ_W'(sq_term);
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq     <= sq + SQ_W'(sq_term);
          root   <= '0;
          bitv   <= SQ_W'(1) << (SQ_W - 1);
          sq_cnt <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if ({1'b0, sq} >= trial) begin
            sq   <= sq - SQ_W'(trial);
            root <= (root >> 1) + {1'b0, bitv};
          end else begin
            root <= root >> 1;
          end
          bitv   <= bitv >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'((SQ_W + 1) / 2 - 1)) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            results.valid <= 1'b1;
            results.data.order_magnitude <=
              (root_rnd > (SQ_W + 1)'(1 << FRAC_BITS)) ? MAG_W'(1 << FRAC_BITS)
                                                       : root_rnd[MAG_W-1:0];
            results.data.points_seen    <= points_done;
            results.data.count_overflow <= overflow_seen;
            points_done    <= '0;
            total_sum_real <= '0;
            total_sum_imag <= '0;
            overflow_seen  <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSI6_ASSERT_ALWAYS(a_bond_bound, bond_count <= BOND_CNT_W'(MAX_BONDS),
    "bond count above its limit")
  `PSI6_ASSERT_NEXT(a_bond_step, state == S_CORD && cor_rsp.done,
    bond_count == $past(bond_count) + 1'b1, "accepted bond not counted")
  `PSI6_ASSERT_NEXT(a_emit_clear, state == S_EMIT && out_free,
    results.valid && points_done == '0 && !overflow_seen, "set end did not clear state")

endmodule

[src/psi6_order_parameter_top.sv]
// Per bond the back end issues the angle, runs the 30-step CORDIC and checks for a
// point end; a point end adds two divides, and a set end adds two more divides, the
// squaring states S_SQ1 and S_SQ2, 18 root steps and the output.
// Throughput is set by the shared iterative CORDIC and divider in the back end;
// a two-entry queue lets angles be taken while the back end works.
// Reset is synchronous and active high; it clears the sums, the bond and point counts and the queue.
module psi6_order_parameter_top
  import psi6_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  psi6_stream_if.sink   items,
  psi6_stream_if.source results
);

  logic    q_valid;
  q_item_t q_data;
  logic    q_pop;

  psi6_front u_front (
    .clk, .rst, .items, .q_valid, .q_data, .q_pop
  );

  psi6_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .results
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the psi6 order parameter block
`timescale 1ns / 1ps

module tb_top;
  import psi6_pkg::*;

  localparam int  HOLD_CYCLES = 1500;
  localparam int  DRAIN_CYCLES = 400;
  localparam int  RANDOM_ITEMS = 630;
  localparam longint PHASE_K = 64'sd1367130551;
  localparam longint GAIN_X = 64'sd652032874;
  localparam longint ATAN_TAB [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41721, 20860,
    10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20, 10, 5, 2, 1};

  logic clk;
  logic rst;

  psi6_stream_if #(.T(in_item_t))  items_if ();
  psi6_stream_if #(.T(out_item_t)) results_if ();

  psi6_order_parameter_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if.sink),
    .results (results_if.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // accumulator state of the order parameter
  longint    acc_bonds, acc_pt_re, acc_pt_im, acc_tot_re, acc_tot_im, acc_points;
  bit        acc_ovf;
  out_item_t magnitude_q[$];

  int bonds_sent, sets_sent, sets_checked, mismatches, burst_left, hold_request;

  function automatic longint round_div(input longint n, input longint d);
    longint m;
    if (d <= 0) return 0;
    m = (n < 0) ? -n : n;
    m = (m + d / 2) / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint frac_clamp(input longint v);
    v = (v + 64'sd8192) >>> 14;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  // exp(i*6*theta) via rotation mode CORDIC
  function automatic void six_fold_unit(input int angle, output longint re,
                                        output longint im);
    longint prod, p, q, z, x, y, nx, c, s;
    logic [63:0] u;
    prod = longint'(angle) * 6 * PHASE_K;
    u = prod + 64'h8000;
    p = longint'({32'd0, u[47:16]});
    q = ((p + 64'sh2000_0000) >> 30) & 3;
    z = (p - (q << 30)) & 64'sh0_FFFF_FFFF;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    x = GAIN_X;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    c = frac_clamp(x);
    s = frac_clamp(y);
    case (q)
      0: begin re = c;  im = s;  end
      1: begin re = -s; im = c;  end
      2: begin re = -c; im = -s; end
      default: begin re = s; im = -c; end
    endcase
  endfunction

  function automatic longint round_sqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  task automatic clear_accum();
    acc_bonds = 0; acc_pt_re = 0; acc_pt_im = 0;
    acc_tot_re = 0; acc_tot_im = 0; acc_points = 0; acc_ovf = 0;
  endtask

  task automatic accumulate_bond(input in_item_t it);
    longint re, im, avg_re, avg_im, m;
    out_item_t res;
    if (acc_bonds >= MAX_BONDS) begin
      acc_ovf = 1;
    end else begin
      six_fold_unit(int'(it.bond_angle), re, im);
      acc_pt_re += re;
      acc_pt_im += im;
      acc_bonds++;
    end
    if (!(it.end_of_point || it.end_of_set)) return;
    if (acc_points >= MAX_POINTS) begin
      acc_ovf = 1;
    end else begin
      acc_tot_re += round_div(acc_pt_re, acc_bonds);
      acc_tot_im += round_div(acc_pt_im, acc_bonds);
      acc_points++;
    end
    acc_bonds = 0; acc_pt_re = 0; acc_pt_im = 0;
    if (!it.end_of_set) return;
    avg_re = round_div(acc_tot_re, acc_points);
    avg_im = round_div(acc_tot_im, acc_points);
    if (avg_re < 0) avg_re = -avg_re;
    if (avg_im < 0) avg_im = -avg_im;
    m = round_sqrt(avg_re * avg_re + avg_im * avg_im);
    if (m > 65536) m = 65536;
    res.order_magnitude = m[16:0];
    res.points_seen     = acc_points[20:0];
    res.count_overflow  = acc_ovf;
    magnitude_q = {magnitude_q, res};
    sets_sent++;
    clear_accum();
  endtask

  // offer one bond in bursts; hold valid across back-to-back transfers
  task automatic send_bond(input int angle, input bit eop, input bit eos);
    in_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    it.bond_angle   = angle[19:0];
    it.end_of_point = eop;
    it.end_of_set   = eos;
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    accumulate_bond(it);
    bonds_sent++;
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  // one set of small points; the last bond may close the set with or without a point end
  task automatic send_set(input int npoints, input int max_bonds);
    int nb;
    for (int pt = 0; pt < npoints; pt++) begin
      nb = $urandom_range(1, max_bonds);
      for (int b = 0; b < nb; b++)
        send_bond(rand_angle(), (b == nb - 1) && (pt != npoints - 1 || $urandom_range(0, 1)),
                  (b == nb - 1) && (pt == npoints - 1));
    end
  endtask

  task automatic test_angle_extremes();
    send_bond(-524288, 1, 0);
    send_bond(524287, 1, 0);
    send_bond(0, 1, 1);
    send_bond(0, 1, 1);
    send_bond(-1, 0, 0);
    send_bond(1, 0, 0);
    send_bond(8579, 1, 0);
    send_bond(-8579, 1, 1);
    // quadrant boundaries, angles in steps near pi/24
    for (int k = -6; k <= 6; k++) send_bond(k * 4289, 0, 0);
    send_bond(17157, 0, 1);
  endtask

  task automatic test_set_without_point_end();
    send_bond(12345, 0, 0);
    send_bond(-23456, 0, 1);
    send_bond(300000, 1, 0);
    send_bond(-300000, 0, 1);
  endtask

  task automatic test_bond_overflow();
    for (int b = 0; b < MAX_BONDS + 6; b++) send_bond(rand_angle(), 0, 0);
    send_bond(rand_angle(), 1, 0);
    send_bond(rand_angle(), 1, 1);
  endtask

  task automatic test_output_backpressure();
    hold_request = 1;
    for (int s = 0; s < 8; s++) send_set($urandom_range(1, 2), 2);
  endtask

  task automatic test_random_sets();
    int start;
    start = bonds_sent;
    while (bonds_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        send_bond(rand_angle(), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
      else if ($urandom_range(0, 19) == 0)
        send_set($urandom_range(1, 3), 70);
      else
        send_set($urandom_range(1, 8), 6);
    end
  endtask

  // receiver stall pattern plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    results_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(0, 7) < 5);
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (magnitude_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %p", results_if.data);
      end else begin
        want = magnitude_q.pop_front();
        sets_checked++;
        if (results_if.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch set %0d: mag exp %0d got %0d, ",
                      "pts exp %0d got %0d, ovf exp %0b got %0b"},
                     sets_checked, want.order_magnitude, results_if.data.order_magnitude,
                     want.points_seen, results_if.data.points_seen,
                     want.count_overflow, results_if.data.count_overflow);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.data  = '0;
    bonds_sent = 0; sets_sent = 0; sets_checked = 0; mismatches = 0;
    burst_left = 0; hold_request = 0;
    clear_accum();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_angle_extremes();
    test_set_without_point_end();
    test_bond_overflow();
    test_output_backpressure();
    test_random_sets();
    items_if.valid <= 1'b0;
    while (magnitude_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bonds in %0d sets, checked %0d set magnitudes, %0d mismatches",
             bonds_sent, sets_sent, sets_checked, mismatches);
    $display("covered angle extremes, bond overflow, set end without point end, long stall");
    if (mismatches == 0 && magnitude_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
